### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the sequence buffer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define ASSERT_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALW(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/isb_pkg.sv
// ----------------------------------------------------------------------------
// isb_pkg
// Types and constants shared by the indexed sequence buffer modules.
// ----------------------------------------------------------------------------
package isb_pkg;

   // Default number of entries the sequence can hold.
   localparam int ISB_DEPTH = 32;

   // Operation codes on the request channel.
   localparam logic [1:0] OP_INS_FRONT = 2'd0;
   localparam logic [1:0] OP_INS_BACK  = 2'd1;
   localparam logic [1:0] OP_DELETE    = 2'd2;

   // Request item.
   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] value;
      logic [5:0]         position;
   } isb_req_type;

   // Result item.
   typedef struct packed {
      logic signed [31:0] item_value;
      logic               list_empty;
      logic               last_item;
      logic               insert_dropped;
   } isb_rsp_type;

   // Classified command handed from the front end to the back end.
   typedef enum logic [1:0] {
      KIND_FRONT,
      KIND_BACK,
      KIND_DELETE,
      KIND_NONE
   } isb_kind_type;

   typedef struct packed {
      isb_kind_type       kind;
      logic signed [31:0] value;
      logic [5:0]         position;
   } isb_cmd_type;

endpackage

### design/indexed_sequence_buffer.sv
// An accepted item waits in the front queue until the back end takes it; the back end runs
// one command at a time and lists every entry after it (one result for an empty list).
// A delete at a valid position first shifts the later entries down. The front queue can
// take new items while the back end is still busy with an earlier command.
// Reset: synchronous, active high; clears count, head pointer and both queues.
// The entry memory is not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
// indexed_sequence_buffer
// Ordered sequence of signed 32-bit entries with insert-front, append and
// delete-at-position; every operation is followed by a full listing.
// ----------------------------------------------------------------------------
module indexed_sequence_buffer import isb_pkg::*; #(
   parameter int DEPTH = ISB_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  isb_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output isb_rsp_type rsp_data
);

   logic        cmd_valid;
   isb_cmd_type cmd;
   logic        cmd_pop;

   // Front end: accepts and decodes items.
   isb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Back end: updates the entries and lists them.
   isb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### design/isb_front.sv
// ----------------------------------------------------------------------------
// isb_front
// Accepts request items, decodes the operation and holds the commands in a
// two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isb_front import isb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  isb_req_type req_data,
   output logic        cmd_valid,
   output isb_cmd_type cmd,
   input  logic        cmd_pop
);

   isb_cmd_type q_ff [2];
   logic        wptr_ff, wptr_in;
   logic        rptr_ff, rptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   isb_cmd_type push_cmd;

   // Decode the operation into a command kind.
   always_comb begin
      push_cmd.value    = req_data.value;
      push_cmd.position = req_data.position;
      case (req_data.op)
         OP_INS_FRONT: push_cmd.kind = KIND_FRONT;
         OP_INS_BACK:  push_cmd.kind = KIND_BACK;
         OP_DELETE:    push_cmd.kind = KIND_DELETE;
         default:      push_cmd.kind = KIND_NONE;
      endcase
   end

   // Queue handshake and pointer updates.
   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ (cmd_pop && cmd_valid);
      cnt_in  = cnt_ff + 2'(push) - 2'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= push_cmd;
      end
   end

   `ASSERT_ALW(a_front_cnt_range, clock, (reset || cnt_ff != 2'd3), "front queue count out of range")
   `ASSERT_RST(a_front_pop_valid, clock, reset, (cmd_pop |-> cmd_valid), "pop from empty front queue")
   `ASSERT_RST(a_front_push_seen, clock, reset, (push && cnt_ff == 2'd0 |=> cmd_valid), "accepted item not queued")

endmodule

### design/isb_back.sv
// ----------------------------------------------------------------------------
// isb_back
// Executes commands on the entry memory, kept as a ring with a head pointer,
// and streams the resulting listing through a two-entry output queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isb_back import isb_pkg::*; #(
   parameter int DEPTH = ISB_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  isb_cmd_type cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output isb_rsp_type rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_LIST
   } state_type;

   // Entry memory and its registered read data.
   logic [31:0]   mem [DEPTH];
   logic [31:0]   rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   // Control state.
   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic          shpend_ff, shpend_in;
   logic          drop_ff, drop_in;
   logic          infl_ff, infl_in;
   logic          infl_last_ff, infl_last_in;
   logic          infl_drop_ff, infl_drop_in;

   // Output queue.
   isb_rsp_type   oq_ff [2];
   logic          owptr_ff, owptr_in;
   logic          orptr_ff, orptr_in;
   logic [1:0]    ocnt_ff, ocnt_in;
   logic          push;
   isb_rsp_type   push_data;
   logic          pop;
   logic          credit;
   logic          full;
   logic [AW-1:0] head_dec;

   // Ring address of a logical index.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] idx);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(idx);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return AW'(sum);
   endfunction

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (ocnt_ff != 2'd0);
   assign rsp_data  = oq_ff[orptr_ff];
   assign full      = (count_ff == CW'(DEPTH));
   assign head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);

   // A read may be issued only when its result is sure to find a queue slot.
   assign credit = ({1'b0, ocnt_ff} + {2'b0, infl_ff}) < (3'd2 + {2'b0, pop});

   // Command execution and listing sequencer.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      wr_idx_in    = wr_idx_ff;
      shpend_in    = shpend_ff;
      drop_in      = drop_ff;
      infl_in      = 1'b0;
      infl_last_in = infl_last_ff;
      infl_drop_in = infl_drop_ff;
      cmd_pop      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      push         = 1'b0;
      push_data    = '0;

      // Data read during the listing is registered and lands here in the next cycle.
      if (infl_ff) begin
         push                     = 1'b1;
         push_data.item_value     = rd_data_ff;
         push_data.last_item      = infl_last_ff;
         push_data.insert_dropped = infl_drop_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               drop_in  = 1'b0;
               idx_in   = '0;
               state_in = ST_LIST;
               case (cmd.kind)
                  KIND_FRONT: begin
                     if (full) begin
                        drop_in = 1'b1;
                     end else begin
                        head_in  = head_dec;
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        wr_data  = cmd.value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_BACK: begin
                     if (full) begin
                        drop_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = phys(head_ff, count_ff);
                        wr_data  = cmd.value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_DELETE: begin
                     if (7'(cmd.position) < 7'(count_ff)) begin
                        idx_in    = CW'(cmd.position) + CW'(1);
                        shpend_in = 1'b0;
                        state_in  = ST_SHIFT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            // Move each later entry down by one, one entry per cycle.
            if (shpend_ff) begin
               wr_en   = 1'b1;
               wr_addr = phys(head_ff, wr_idx_ff);
               wr_data = rd_data_ff;
            end
            if (idx_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_addr   = phys(head_ff, idx_ff);
               shpend_in = 1'b1;
               wr_idx_in = idx_ff - CW'(1);
               idx_in    = idx_ff + CW'(1);
            end else begin
               shpend_in = 1'b0;
               count_in  = count_ff - CW'(1);
               idx_in    = '0;
               state_in  = ST_LIST;
            end
         end

         ST_LIST: begin
            if (count_ff == '0) begin
               if (credit && !infl_ff) begin
                  push                     = 1'b1;
                  push_data.list_empty     = 1'b1;
                  push_data.last_item      = 1'b1;
                  push_data.insert_dropped = drop_ff;
                  state_in                 = ST_IDLE;
               end
            end else if (credit) begin
               rd_en        = 1'b1;
               rd_addr      = phys(head_ff, idx_ff);
               infl_in      = 1'b1;
               infl_last_in = (idx_ff == count_ff - CW'(1));
               infl_drop_in = drop_ff;
               idx_in       = idx_ff + CW'(1);
               if (idx_ff == count_ff - CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output queue pointers.
   always_comb begin
      owptr_in = owptr_ff ^ push;
      orptr_in = orptr_ff ^ pop;
      ocnt_in  = ocnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         wr_idx_ff    <= '0;
         shpend_ff    <= 1'b0;
         drop_ff      <= 1'b0;
         infl_ff      <= 1'b0;
         infl_last_ff <= 1'b0;
         infl_drop_ff <= 1'b0;
         owptr_ff     <= 1'b0;
         orptr_ff     <= 1'b0;
         ocnt_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         wr_idx_ff    <= wr_idx_in;
         shpend_ff    <= shpend_in;
         drop_ff      <= drop_in;
         infl_ff      <= infl_in;
         infl_last_ff <= infl_last_in;
         infl_drop_ff <= infl_drop_in;
         owptr_ff     <= owptr_in;
         orptr_ff     <= orptr_in;
         ocnt_ff      <= ocnt_in;
      end
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Output queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         oq_ff[owptr_ff] <= push_data;
      end
   end

   `ASSERT_RST(a_back_count_max, clock, reset, (count_ff <= CW'(DEPTH)), "entry count above depth")
   `ASSERT_RST(a_back_no_overflow, clock, reset, (ocnt_ff == 2'd2 && !pop |-> !push), "output queue overflow")
   `ASSERT_RST(a_back_shift_nonempty, clock, reset, (state_ff == ST_SHIFT |-> count_ff != '0), "shift on empty list")
   `ASSERT_RST(a_back_infl_push, clock, reset, (infl_ff |-> push), "listing read lost")

endmodule

### tb/indexed_sequence_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_buffer_tb
// Drives insert-front, append and delete items into the sequence buffer and
// checks every listed result against a shadow copy of the list or a known result. A short
// directed part covers the empty, out-of-range and unused-opcode cases.
// A random part then grows the list until it is full and shrinks it again,
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module indexed_sequence_buffer_tb;
   import isb_pkg::*;

   localparam int LIST_DEPTH    = ISB_DEPTH;
   localparam int RANDOM_ITEMS  = 113;
   localparam int MAX_ITEMS     = 400;
   localparam int IDLE_LIMIT    = 4000;
   localparam int PRESSURE_AT   = 120;
   localparam int PRESSURE_HOLD = 300;
   localparam int TAIL_CYCLES   = 2 * LIST_DEPTH + 16;
   localparam int FULL_REPEATS  = 3;

   // The opcode that the package leaves unassigned.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam isb_rsp_type EMPTY_LISTING = '{32'sd0, 1'b1, 1'b1, 1'b0};
   localparam isb_rsp_type NO_LISTING    = '{32'sd0, 1'b0, 1'b0, 1'b0};

   // One directed row: the item and, where it is obvious, its single result.
   typedef struct packed {
      isb_req_type req;
      logic        typed;
      isb_rsp_type known;
   } stim_row_type;

   localparam int NUM_DIRECTED = 17;
   localparam stim_row_type DIRECTED_OPS [NUM_DIRECTED] = '{
      // Empty list: delete, unused opcode and delete at the top position.
      '{'{OP_DELETE,    32'sd0,           6'd0},  1'b1, EMPTY_LISTING},
      '{'{OP_UNUSED,    32'sh7FFFFFFF,    6'd63}, 1'b1, EMPTY_LISTING},
      '{'{OP_DELETE,    32'sh7FFFFFFF,    6'd63}, 1'b1, EMPTY_LISTING},
      // Single entries at the value extremes.
      '{'{OP_INS_FRONT, 32'sh7FFFFFFF,    6'd63},
        1'b1, '{32'sh7FFFFFFF, 1'b0, 1'b1, 1'b0}},
      '{'{OP_DELETE,    32'sd0,           6'd0},  1'b1, EMPTY_LISTING},
      '{'{OP_INS_BACK,  32'sh80000000,    6'd0},
        1'b1, '{32'sh80000000, 1'b0, 1'b1, 1'b0}},
      // Build a short list from both ends.
      '{'{OP_INS_BACK,  32'shFFFFFFFF,    6'd0},  1'b0, NO_LISTING},
      '{'{OP_INS_FRONT, 32'sd0,           6'd63}, 1'b0, NO_LISTING},
      '{'{OP_INS_BACK,  32'sd1,           6'd21}, 1'b0, NO_LISTING},
      '{'{OP_INS_FRONT, 32'sh2AAAAAAA,    6'd42}, 1'b0, NO_LISTING},
      '{'{OP_INS_BACK,  32'sh55555555,    6'd21}, 1'b0, NO_LISTING},
      // Delete the last, the first and a middle entry.
      '{'{OP_DELETE,    32'sh12345678,    6'd5},  1'b0, NO_LISTING},
      '{'{OP_DELETE,    32'sd0,           6'd0},  1'b0, NO_LISTING},
      '{'{OP_DELETE,    32'shFFFFFFFF,    6'd1},  1'b0, NO_LISTING},
      // Positions at and far beyond the count leave the list unchanged.
      '{'{OP_DELETE,    32'sd0,           6'd3},  1'b0, NO_LISTING},
      '{'{OP_DELETE,    32'sh7FFFFFFF,    6'd32}, 1'b0, NO_LISTING},
      '{'{OP_UNUSED,    32'sh80000000,    6'd0},  1'b0, NO_LISTING}
   };

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   isb_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   isb_rsp_type rsp_data;

   // Shadow copy of the list and the listing still owed by the block.
   logic signed [31:0] shadow_list [$];
   isb_rsp_type        pending_listing [$];

   int  mismatch_count = 0;
   int  results_seen   = 0;
   int  idle_cycles    = 0;
   bit  send_fast      = 1'b0;

   indexed_sequence_buffer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Applies one operation to the shadow list and, if asked, queues the
   // listing that the block should produce for it.
   function automatic void apply_list_op(input isb_req_type r, input bit queue_listing);
      bit          dropped;
      isb_rsp_type want;
      dropped = 1'b0;
      case (r.op)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (shadow_list.size() >= LIST_DEPTH) begin
               dropped = 1'b1;
            end else if (r.op == OP_INS_FRONT) begin
               shadow_list.push_front(r.value);
            end else begin
               shadow_list.push_back(r.value);
            end
         end
         OP_DELETE: begin
            if (int'(r.position) < shadow_list.size()) begin
               shadow_list.delete(int'(r.position));
            end
         end
         default: ;
      endcase
      if (!queue_listing) return;
      if (shadow_list.size() == 0) begin
         want = EMPTY_LISTING;
         want.insert_dropped = dropped;
         pending_listing.push_back(want);
      end else begin
         foreach (shadow_list[i]) begin
            want.item_value     = shadow_list[i];
            want.list_empty     = 1'b0;
            want.last_item      = (i == shadow_list.size() - 1);
            want.insert_dropped = dropped;
            pending_listing.push_back(want);
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] result %0d: %s got %h expected %h", $time, results_seen, what,
               got, want);
      mismatch_count++;
   endtask

   // Offers one item after a random gap and waits until it is accepted.
   task automatic send_item(input isb_req_type r, input bit typed, input isb_rsp_type known);
      int gap;
      if ($urandom_range(0, 15) == 0) send_fast = !send_fast;
      gap = send_fast ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_list_op(r, !typed);
      if (typed) pending_listing.push_back(known);
   endtask

   // Reset, the directed rows, then a random part that fills and drains the list.
   initial begin : stimulus
      isb_req_type r;
      int          issued;
      int          roll;
      int          at_full;
      bit          growing;
      bit          reached_full;
      issued       = 0;
      at_full      = 0;
      growing      = 1'b1;
      reached_full = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < NUM_DIRECTED; k++) begin
         send_item(DIRECTED_OPS[k].req, DIRECTED_OPS[k].typed, DIRECTED_OPS[k].known);
      end

      while ((issued < RANDOM_ITEMS || !reached_full) && issued < MAX_ITEMS) begin
         roll       = $urandom_range(0, 99);
         r.value    = $urandom;
         r.position = 6'($urandom_range(0, 63));
         if (growing) begin
            if (roll < 85) begin
               r.op = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
            end else if (roll < 95) begin
               r.op = OP_DELETE;
            end else begin
               r.op = OP_UNUSED;
            end
         end else begin
            if (roll < 80) begin
               r.op = OP_DELETE;
               if (shadow_list.size() > 0) begin
                  r.position = 6'($urandom_range(0, shadow_list.size() - 1));
               end
            end else if (roll < 90) begin
               r.op = OP_DELETE;
            end else if (roll < 95) begin
               r.op = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
            end else begin
               r.op = OP_UNUSED;
            end
         end
         send_item(r, 1'b0, NO_LISTING);
         issued++;

         // A few inserts bounce off the full list before it is drained again.
         if (growing && shadow_list.size() == LIST_DEPTH) begin
            at_full++;
            if (at_full > FULL_REPEATS) begin
               growing      = 1'b0;
               at_full      = 0;
               reached_full = 1'b1;
            end
         end else if (!growing && shadow_list.size() == 0) begin
            growing = 1'b1;
         end
      end
      req_valid <= 1'b0;

      while (pending_listing.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Result side: random stalls, bursts without stalls, and one long hold-off
   // that lets the block fill up and refuse new items.
   initial begin : result_drain
      int stall;
      int taken;
      bit drain_fast;
      bit held;
      taken      = 0;
      drain_fast = 1'b0;
      held       = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) drain_fast = !drain_fast;
         stall = drain_fast ? 0 : $urandom_range(0, 12);
         if (!held && taken >= PRESSURE_AT) begin
            stall = PRESSURE_HOLD;
            held  = 1'b1;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   // Compare each accepted result with the oldest expected one.
   always @(posedge clock) begin : check_results
      isb_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_listing.size() == 0) begin
            report_mismatch("unexpected result, item_value", rsp_data.item_value, '0);
         end else begin
            want = pending_listing.pop_front();
            if (rsp_data.item_value !== want.item_value)
               report_mismatch("item_value", rsp_data.item_value, want.item_value);
            if (rsp_data.list_empty !== want.list_empty)
               report_mismatch("list_empty", 32'(rsp_data.list_empty), 32'(want.list_empty));
            if (rsp_data.last_item !== want.last_item)
               report_mismatch("last_item", 32'(rsp_data.last_item), 32'(want.last_item));
            if (rsp_data.insert_dropped !== want.insert_dropped)
               report_mismatch("insert_dropped", 32'(rsp_data.insert_dropped),
                               32'(want.insert_dropped));
         end
         results_seen++;
      end
   end

   // Watchdog: too long without any item moving on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("[%0t] no item accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

endmodule

### files.f
+incdir+design
design/isb_pkg.sv
design/isb_front.sv
design/isb_back.sv
design/indexed_sequence_buffer.sv
tb/indexed_sequence_buffer_tb.sv
